// File: hdl/tcw_pkg.sv
// Shared definitions for the text console writer: field widths, item kinds,
// character codes and the step control bundle.
// No dependencies; every other file of the block but tcw_screen_ram refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   // Default screen geometry.
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Fixed widths of the channel fields.
   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int CELL_W      = 16;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   // Character codes and cell values.
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CELL_W-1:0] BLANK_CELL     = 16'h0720;

   // What an accepted item asks of the sequencer and the screen store.
   typedef struct packed {
      logic wr_en;     // one cell is written at the step address
      logic scroll;    // the cursor ran past the last row
      logic clear;     // blank the whole screen
      logic read_hit;  // in-range cell read at the step address
   } step_ctl_type;

endpackage

`default_nettype wire

// File: hdl/tcw_screen_ram.sv
// Character-cell screen store: one write port and one read port, with a
// registered read that holds its data between reads. Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/tcw_cursor.sv
// Cursor registers and the per-item decode: next cursor position, the cell
// address and data for a write or a read, and the step control bundle.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cursor #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               accept,
   input  wire logic [tcw_pkg::KIND_W-1:0]         kind,
   input  wire logic [tcw_pkg::CHAR_W-1:0]         char_code,
   input  wire logic [tcw_pkg::ATTR_W-1:0]         color,
   input  wire logic [tcw_pkg::ROW_FIELD_W-1:0]    read_row,
   input  wire logic [tcw_pkg::COL_FIELD_W-1:0]    read_col,
   output      logic [$clog2(COLUMNS)-1:0]         cur_col,
   output      logic [$clog2(ROWS)-1:0]            cur_row,
   output      tcw_pkg::step_ctl_type              ctl,
   output      logic [$clog2(COLUMNS*ROWS)-1:0]    cell_addr,
   output      logic [tcw_pkg::CELL_W-1:0]         wr_data
);

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);
   localparam int AW = $clog2(COLUMNS*ROWS);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          is_put, is_newline, is_backspace, is_print, is_read;
   logic          col_last, col_zero, row_last, advance_row, in_range;
   logic [RW-1:0] sel_row;
   logic [CW-1:0] sel_col;

   always_comb begin
      is_put       = (kind == tcw_pkg::KIND_PUT);
      is_read      = (kind == tcw_pkg::KIND_READ);
      is_newline   = is_put && (char_code == tcw_pkg::CHAR_NEWLINE);
      is_backspace = is_put && (char_code == tcw_pkg::CHAR_BACKSPACE);
      is_print     = is_put && !is_newline && !is_backspace;

      col_last = (col_ff == CW'(COLUMNS - 1));
      col_zero = (col_ff == '0);
      row_last = (row_ff == RW'(ROWS - 1));
      in_range = (32'(read_row) < 32'(ROWS)) && (32'(read_col) < 32'(COLUMNS));

      // A printable character in the last column wraps like a newline.
      advance_row = is_newline || (is_print && col_last);

      ctl.wr_en    = is_print || (is_backspace && !col_zero);
      ctl.scroll   = advance_row && row_last;
      ctl.clear    = (kind == tcw_pkg::KIND_CLEAR);
      ctl.read_hit = is_read && in_range;

      col_in = col_ff;
      row_in = row_ff;
      if (ctl.clear) begin
         col_in = '0;
         row_in = '0;
      end else if (advance_row) begin
         // Past the last row the screen scrolls and the cursor stays there.
         col_in = '0;
         row_in = row_last ? row_ff : row_ff + RW'(1);
      end else if (is_print) begin
         col_in = col_ff + CW'(1);
      end else if (is_backspace && !col_zero) begin
         col_in = col_ff - CW'(1);
      end

      // One index unit serves both the write at the cursor and a cell read.
      sel_row = is_read ? RW'(read_row) : row_ff;
      if (is_read) begin
         sel_col = CW'(read_col);
      end else if (is_backspace) begin
         sel_col = col_ff - CW'(1);
      end else begin
         sel_col = col_ff;
      end
      cell_addr = AW'(32'(sel_row) * COLUMNS) + AW'(sel_col);

      wr_data = {color, is_backspace ? tcw_pkg::CHAR_SPACE : char_code};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign cur_col = col_ff;
   assign cur_row = row_ff;

endmodule

`default_nettype wire

// File: hdl/text_console_writer_unit.sv
// Text console writer top level: item sequencer, screen sweeps and the
// result register. Depends on tcw_pkg, tcw_cursor and tcw_screen_ram.
//
// Usage: items arrive on the req_ channel (valid/ready). Each accepted item
// gives exactly one result beat on the rsp_ channel carrying the cursor
// after the step, the scroll flag and, for an in-range cell read, the cell contents.
// A put (character, newline or backspace), a read or an unused kind goes
// from idle to the EMIT state, which loads the result beat once the output
// register is free and then returns to idle. A put that runs past the last
// row scrolls the screen: one pass over the store copies each row up and
// blanks the bottom row before the result is loaded. A clear blanks every
// cell in one pass. The single write port of the screen store makes each
// sweep go one cell at a time. After reset the block blanks the store in a
// clearing pass with req_ready low, and the cursor sits at row 0, column 0.
// The result sits in an output register: the next item is accepted while a
// beat still waits, and a stalled receiver only holds back the load of the
// following result.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [tcw_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [tcw_pkg::CHAR_W-1:0]       req_char_code,
   input  wire logic [tcw_pkg::ATTR_W-1:0]       req_color,
   input  wire logic [tcw_pkg::ROW_FIELD_W-1:0]  req_read_row,
   input  wire logic [tcw_pkg::COL_FIELD_W-1:0]  req_read_col,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [tcw_pkg::COL_FIELD_W-1:0]  rsp_cursor_col,
   output      logic [tcw_pkg::ROW_FIELD_W-1:0]  rsp_cursor_row,
   output      logic                             rsp_scrolled,
   output      logic [tcw_pkg::CELL_W-1:0]       rsp_cell_data
);

   localparam int CELLS      = COLUMNS * ROWS;
   localparam int AW         = $clog2(CELLS);
   localparam int CNT_W      = $clog2(CELLS + 1);
   localparam int CW         = $clog2(COLUMNS);
   localparam int RW         = $clog2(ROWS);
   localparam int SHIFT_LAST = CELLS - COLUMNS;

   typedef enum logic [4:0] {
      ST_INIT   = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCROLL = 5'b00100,
      ST_CLEAR  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic                        scrolled_ff, scrolled_in;
   logic                        hit_ff, hit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::COL_FIELD_W-1:0] rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::ROW_FIELD_W-1:0] rsp_row_ff, rsp_row_in;
   logic                        rsp_scrolled_ff, rsp_scrolled_in;
   logic [tcw_pkg::CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic                        accept, out_free;
   logic [CW-1:0]               cur_col;
   logic [RW-1:0]               cur_row;
   tcw_pkg::step_ctl_type       ctl;
   logic [AW-1:0]               cell_addr;
   logic [tcw_pkg::CELL_W-1:0]  step_data;

   logic                        ram_wr_en, ram_rd_en;
   logic [AW-1:0]               ram_wr_addr, ram_rd_addr;
   logic [tcw_pkg::CELL_W-1:0]  ram_wr_data, ram_rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .char_code (req_char_code),
      .color     (req_color),
      .read_row  (req_read_row),
      .read_col  (req_read_col),
      .cur_col   (cur_col),
      .cur_row   (cur_row),
      .ctl       (ctl),
      .cell_addr (cell_addr),
      .wr_data   (step_data)
   );

   tcw_screen_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (AW),
      .DATA_W (tcw_pkg::CELL_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Store port selection. During a scroll the read runs one row ahead of
   // the write, so the copy never reads a cell it has already overwritten.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cell_addr;
      ram_wr_data = step_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cell_addr;
      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(idx_ff);
            ram_wr_data = tcw_pkg::BLANK_CELL;
         end
         ST_IDLE: begin
            ram_wr_en = accept && ctl.wr_en;
            ram_rd_en = accept && ctl.read_hit;
         end
         ST_SCROLL: begin
            ram_wr_en   = (idx_ff != '0);
            ram_wr_addr = AW'(idx_ff - CNT_W'(1));
            ram_wr_data = (idx_ff <= CNT_W'(SHIFT_LAST)) ? ram_rd_data
                                                          : tcw_pkg::BLANK_CELL;
            ram_rd_en   = (idx_ff < CNT_W'(SHIFT_LAST));
            ram_rd_addr = AW'(idx_ff + CNT_W'(COLUMNS));
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      scrolled_in     = scrolled_ff;
      hit_in          = hit_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_col_in      = rsp_col_ff;
      rsp_row_in      = rsp_row_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_cell_in     = rsp_cell_ff;
      case (state_ff)
         ST_INIT: begin
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               scrolled_in = ctl.scroll;
               hit_in      = ctl.read_hit;
               idx_in      = '0;
               if (ctl.clear) begin
                  state_in = ST_CLEAR;
               end else if (ctl.scroll) begin
                  state_in = ST_SCROLL;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CLEAR: begin
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(CELLS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_SCROLL: begin
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(CELLS)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_col_in      = tcw_pkg::COL_FIELD_W'(cur_col);
               rsp_row_in      = tcw_pkg::ROW_FIELD_W'(cur_row);
               rsp_scrolled_in = scrolled_ff;
               rsp_cell_in     = hit_ff ? ram_rd_data : '0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         scrolled_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         scrolled_ff  <= scrolled_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff      <= rsp_col_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_cell_ff     <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_cell_data  = rsp_cell_ff;

endmodule

`default_nettype wire

// File: hdl/tcw_checker.sv
// Port-level checks for the text console writer and the bind that attaches
// them to text_console_writer_unit. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [tcw_pkg::KIND_W-1:0]       req_kind,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [tcw_pkg::COL_FIELD_W-1:0]  rsp_cursor_col,
   input wire logic                             rsp_scrolled,
   input wire logic [tcw_pkg::CELL_W-1:0]       rsp_cell_data
);

   // A waiting result beat must hold until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_data)
                                  && $stable(rsp_cursor_col))
      else $error("result beat changed while stalled");

   // The clearing pass keeps input closed right after reset.
   a_init_closed: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("input open during the clearing pass");

   // Items are handled one at a time, never in consecutive cycles.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted in back-to-back cycles");

   // A scroll leaves the cursor in column zero and never carries cell data.
   a_scroll_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_col == '0 && rsp_cell_data == '0)
      else $error("scrolled result with bad column or cell data");

   // A clear item keeps input closed during its sweep (checked at a single sample inside it).
   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == tcw_pkg::KIND_CLEAR |=> ##1 !req_ready)
      else $error("input open during a clear sweep");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_scrolled   (rsp_scrolled),
   .rsp_cell_data  (rsp_cell_data)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Testbench for text_console_writer_unit: directed cases, then random console traffic.
// It keeps its own copy of the screen and cursor to predict every result beat.
// Depends on tcw_pkg and the text_console_writer_unit RTL.
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   localparam int COLUMNS = COLUMNS_DEF;
   localparam int ROWS    = ROWS_DEF;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [COL_FIELD_W-1:0] col;
      logic [ROW_FIELD_W-1:0] row;
      logic                   scrolled;
      logic [CELL_W-1:0]      cell_word;
   } console_report_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind;
   logic [CHAR_W-1:0]      req_char_code;
   logic [ATTR_W-1:0]      req_color;
   logic [ROW_FIELD_W-1:0] req_read_row;
   logic [COL_FIELD_W-1:0] req_read_col;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [COL_FIELD_W-1:0] rsp_cursor_col;
   logic [ROW_FIELD_W-1:0] rsp_cursor_row;
   logic                   rsp_scrolled;
   logic [CELL_W-1:0]      rsp_cell_data;

   // Our own copy of the screen store and cursor.
   logic [CELL_W-1:0] screen_copy [CELLS];
   int                cur_col;
   int                cur_row;

   console_report_type awaited_reports [$];
   int                 fail_count = 0;
   int                 items_sent = 0;
   bit                 idling_on  = 1'b0;

   text_console_writer_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_color      (req_color),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_scrolled   (rsp_scrolled),
      .rsp_cell_data  (rsp_cell_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void blank_screen_copy();
      for (int i = 0; i < CELLS; i++) screen_copy[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
   endfunction

   // Moves the cursor to the start of the next row and scrolls when it falls
   // off the bottom. Returns whether the screen scrolled.
   function automatic logic step_to_next_row();
      cur_col = 0;
      cur_row++;
      if (cur_row < ROWS) return 1'b0;
      for (int i = 0; i + COLUMNS < CELLS; i++) screen_copy[i] = screen_copy[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_copy[i] = BLANK_CELL;
      cur_row = ROWS - 1;
      return 1'b1;
   endfunction

   function automatic console_report_type predict_console_step(
      input logic [KIND_W-1:0]      kind,
      input logic [CHAR_W-1:0]      ch,
      input logic [ATTR_W-1:0]      attr,
      input logic [ROW_FIELD_W-1:0] rrow,
      input logic [COL_FIELD_W-1:0] rcol
   );
      console_report_type rep;
      rep = '0;
      case (kind)
         KIND_PUT: begin
            if (ch == CHAR_NEWLINE) begin
               rep.scrolled = step_to_next_row();
            end else if (ch == CHAR_BACKSPACE) begin
               if (cur_col > 0) begin
                  cur_col--;
                  screen_copy[cur_row * COLUMNS + cur_col] = {attr, CHAR_SPACE};
               end
            end else begin
               screen_copy[cur_row * COLUMNS + cur_col] = {attr, ch};
               cur_col++;
               if (cur_col >= COLUMNS) rep.scrolled = step_to_next_row();
            end
         end
         KIND_CLEAR: blank_screen_copy();
         KIND_READ: begin
            if (rrow < ROWS && rcol < COLUMNS)
               rep.cell_word = screen_copy[rrow * COLUMNS + rcol];
         end
         default: ;
      endcase
      rep.col = cur_col[COL_FIELD_W-1:0];
      rep.row = cur_row[ROW_FIELD_W-1:0];
      return rep;
   endfunction

   // Sends one item, starting and ending at a falling edge. The valid line
   // stays high between back-to-back items.
   task automatic send_item(
      input logic [KIND_W-1:0]      kind,
      input logic [CHAR_W-1:0]      ch,
      input logic [ATTR_W-1:0]      attr,
      input logic [ROW_FIELD_W-1:0] rrow,
      input logic [COL_FIELD_W-1:0] rcol
   );
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind      <= kind;
      req_char_code <= ch;
      req_color     <= attr;
      req_read_row  <= rrow;
      req_read_col  <= rcol;
      req_valid     <= 1'b1;
      do begin
         @(posedge clock);
      end while (!req_ready);
      awaited_reports.push_back(predict_console_step(kind, ch, attr, rrow, rcol));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] attr);
      send_item(KIND_PUT, ch, attr, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
   endtask

   task automatic read_cell(input int rrow, input int rcol);
      send_item(KIND_READ, CHAR_W'($urandom), ATTR_W'($urandom),
                ROW_FIELD_W'(rrow), COL_FIELD_W'(rcol));
   endtask

   task automatic clear_screen();
      send_item(KIND_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom),
                ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
   endtask

   // A random byte that is printed rather than treated as a control code.
   function automatic logic [CHAR_W-1:0] random_glyph();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom); while (ch == CHAR_NEWLINE || ch == CHAR_BACKSPACE);
      return ch;
   endfunction

   task automatic test_extremes_and_reads();
      read_cell(0, 0);
      read_cell(ROWS - 1, COLUMNS - 1);
      clear_screen();
      put_char(8'h00, 8'h00);
      put_char(8'hFF, 8'hFF);
      read_cell(0, 0);
      read_cell(0, 1);
      read_cell(ROWS, 0);
      read_cell(0, COLUMNS);
      read_cell(31, 127);
      send_item(KIND_UNUSED, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
      send_item(KIND_UNUSED, 8'h00, 8'h00, 5'h00, 7'h00);
   endtask

   task automatic test_backspace();
      clear_screen();
      put_char(CHAR_BACKSPACE, 8'h4E);
      put_char("A", 8'h1F);
      put_char(CHAR_BACKSPACE, 8'hC3);
      read_cell(0, 0);
      put_char(CHAR_NEWLINE, 8'h00);
      read_cell(0, 1);
   endtask

   task automatic test_row_wrap();
      put_char(CHAR_NEWLINE, ATTR_W'($urandom));
      for (int i = 0; i < COLUMNS; i++) put_char(random_glyph(), ATTR_W'($urandom));
      read_cell(cur_row - 1, 0);
      read_cell(cur_row - 1, COLUMNS - 1);
      read_cell(cur_row, 0);
   endtask

   // Scroll both by newline on the bottom row and by a wrap off its end.
   task automatic test_scroll();
      clear_screen();
      put_char("x", 8'h2A);
      put_char(CHAR_NEWLINE, 8'h00);
      put_char("y", 8'h5B);
      for (int i = 0; i < ROWS - 2; i++) put_char(CHAR_NEWLINE, ATTR_W'($urandom));
      put_char("z", 8'h6C);
      put_char(CHAR_NEWLINE, 8'h00);
      read_cell(0, 0);
      read_cell(ROWS - 2, 0);
      read_cell(ROWS - 1, 0);
      for (int i = 0; i < COLUMNS; i++) put_char(random_glyph(), ATTR_W'($urandom));
      read_cell(ROWS - 2, COLUMNS - 1);
      read_cell(ROWS - 1, 0);
   endtask

   // Sends random traffic until count more items have gone out.
   task automatic test_random_traffic(input int count, input bit with_idling);
      int pick;
      int stop_at;
      idling_on = with_idling;
      stop_at   = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            put_char(CHAR_W'($urandom), ATTR_W'($urandom));
         end else if (pick < 68) begin
            put_char(CHAR_NEWLINE, ATTR_W'($urandom));
         end else if (pick < 75) begin
            put_char(CHAR_BACKSPACE, ATTR_W'($urandom));
         end else if (pick < 87) begin
            if ($urandom_range(0, 4) == 0)
               read_cell($urandom_range(0, 31), $urandom_range(0, 127));
            else
               read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
         end else if (pick < 93) begin
            // Read back the cell left of the cursor, or the one under it in column zero.
            read_cell(cur_row, (cur_col > 0) ? cur_col - 1 : cur_col);
         end else if (pick < 95) begin
            send_item(KIND_UNUSED, CHAR_W'($urandom), ATTR_W'($urandom),
                      ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom));
         end else if (pick < 96) begin
            clear_screen();
         end else begin
            // Park the cursor near the right edge to make wraps common.
            while (cur_col < COLUMNS - 3) put_char(random_glyph(), ATTR_W'($urandom));
         end
      end
   endtask

   // Receiver side: random stall bursts while idling is on.
   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Every result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      console_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_reports.size() == 0) begin
            $error("result beat with no prediction pending");
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_cursor_col !== want.col) begin
               $error("cursor_col: expected %0d, got %0d", want.col, rsp_cursor_col);
               fail_count++;
            end
            if (rsp_cursor_row !== want.row) begin
               $error("cursor_row: expected %0d, got %0d", want.row, rsp_cursor_row);
               fail_count++;
            end
            if (rsp_scrolled !== want.scrolled) begin
               $error("scrolled: expected %0d, got %0d", want.scrolled, rsp_scrolled);
               fail_count++;
            end
            if (rsp_cell_data !== want.cell_word) begin
               $error("cell_data: expected %h, got %h", want.cell_word, rsp_cell_data);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #200_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_PUT;
      req_char_code = '0;
      req_color     = '0;
      req_read_row  = '0;
      req_read_col  = '0;
      blank_screen_copy();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes_and_reads();
      test_backspace();
      idling_on = 1'b1;
      test_row_wrap();
      test_scroll();
      test_random_traffic(500, 1'b1);
      test_random_traffic(180, 1'b0);
      test_random_traffic(300, 1'b1);
      test_random_traffic(150, 1'b0);
      req_valid <= 1'b0;

      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
